[rtl/sie_pkg.sv]
// ----------------------------------------------------------------------------
// sie_pkg
// Widths, register indexes and field layout shared by the interval estimator.
// ----------------------------------------------------------------------------
package sie_pkg;

  localparam int TIME_W    = 64;  // timestamp width
  localparam int DIGIT_W   = 4;   // digit width of the serial subtractor
  localparam int SAMP_W    = 6;   // batch sample count field
  localparam int TOTAL_W   = 40;  // interval sum, whole us
  localparam int SAMPLES_W = 21;  // sample sum
  localparam int TALLY_W   = 16;  // interval count
  localparam int EST_W     = 32;  // fixed-point estimates
  localparam int CFG_W     = 20;  // widest config register
  localparam int WIN_W     = 16;  // window count registers
  localparam int CFG_ADDR_W = 2;

  localparam int IN_DATA_W  = 72; // arrival_time + batch_samples, byte padded
  localparam int OUT_DATA_W = 64; // two estimates

  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_IV    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_IV    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG_WIN  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_WIN = 2'd3;

endpackage

[rtl/sie_serial_sub.sv]
// ----------------------------------------------------------------------------
// sie_serial_sub
// Digit-serial subtractor: minuend - subtrahend modulo 2^TIME_W, one digit
// per cycle starting at the least significant digit.
// ----------------------------------------------------------------------------
module sie_serial_sub
  import sie_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] minuend_i,
  input  logic [TIME_W-1:0] subtrahend_i,
  output logic              done_o,
  output logic [TIME_W-1:0] diff_o
);

  localparam int NDIG  = TIME_W / DIGIT_W;
  localparam int CNT_W = $clog2(NDIG);

  logic [TIME_W-1:0] a_q, b_q, diff_q;
  logic              borrow_q;
  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIGIT_W:0]  step;

  assign step = {1'b0, a_q[DIGIT_W-1:0]} - {1'b0, b_q[DIGIT_W-1:0]}
              - {{DIGIT_W{1'b0}}, borrow_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NDIG - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q      <= minuend_i;
      b_q      <= subtrahend_i;
      borrow_q <= 1'b0;
    end else if (busy_q) begin
      a_q      <= a_q >> DIGIT_W;
      b_q      <= b_q >> DIGIT_W;
      borrow_q <= step[DIGIT_W];
      diff_q   <= {step[DIGIT_W-1:0], diff_q[TIME_W-1:DIGIT_W]};
    end
  end

  assign done_o = done_q;
  assign diff_o = diff_q;

endmodule

[rtl/sie_serial_div.sv]
// ----------------------------------------------------------------------------
// sie_serial_div
// Restoring divider, one quotient bit per cycle, MSB first. A zero divisor
// yields an all-ones quotient.
// ----------------------------------------------------------------------------
module sie_serial_div #(
  parameter int DW = 49,
  parameter int VW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DW);

  logic [VW-1:0]    rem_q, dvs_q;
  logic [DW-1:0]    quo_q;
  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [VW:0]      trial, trial_sub;
  logic             ge;

  assign trial     = {rem_q, quo_q[DW-1]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial_sub[VW-1:0] : trial[VW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/sample_interval_estimator.sv]
// ----------------------------------------------------------------------------
// sample_interval_estimator
// Batch interval estimator: accumulates accepted inter-batch intervals and
// derives rounded average batch and per-sample intervals (unsigned fixed
// point, FRAC_BITS fraction bits).
//
//   channel   dir  handshake                fields
//   s_axis    in   tvalid/tready            tdata: arrival_time, batch_samples
//                                           tuser: gap_seen
//   m_axis    out  tvalid/tready            tdata: batch est, sample est
//                                           tuser: estimate_changed
//   cfg       in   cfg_we_i                 cfg_addr_i, cfg_wdata_i
//
// Gap beat: goes straight from idle to the output state. Ordinary beat: waits on the
// 4-bit serial timestamp subtractor (16 digits).
// A beat that closes a window then runs the divide, difference and update states;
// both averages run on two serial dividers side by side.
// Reset clears the FSM, accumulators, estimates and valid flag and loads the register
// defaults; no clearing pass. A finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module sample_interval_estimator
  import sie_pkg::*;
#(
  parameter int MAX_BATCH = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [63:0] arrival_time, [69:64] batch_samples
  input  logic                  s_axis_tuser,   // [0] gap_seen
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] batch_interval_est,
                                                // [63:32] sample_interval_est
  output logic                  m_axis_tuser,   // [0] estimate_changed
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  localparam int DW  = TOTAL_W + FRAC_BITS + 1;   // rounded dividend
  localparam int CW  = EST_W + FRAC_BITS + 2;     // bound compare width
  localparam int NW  = TALLY_W + 1;               // incremented count
  localparam int MW  = EST_W + 8;                 // 200 * diff
  localparam logic [7:0] MaxBatch = 8'(MAX_BATCH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUB   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_DIV0  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DIFF  = 3'd5;
  localparam logic [2:0] ST_UPD   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0] state_q;

  // configuration
  logic [CFG_W-1:0] max_iv_q, min_iv_q;
  logic [WIN_W-1:0] long_win_q, first_win_q;

  // estimator state
  logic [TIME_W-1:0]    prev_q, now_q;
  logic [TOTAL_W-1:0]   total_q;
  logic [SAMPLES_W-1:0] stot_q;
  logic [TALLY_W-1:0]   tally_q;
  logic [EST_W-1:0]     be_q, se_q;
  logic [SAMP_W-1:0]    samp_q;
  logic [NW-1:0]        n_q;
  logic [EST_W-1:0]     avg_q, savg_q, diff_q;
  logic                 changed_q;

  // output register
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                  m_user_q;

  logic s_hs, m_hs, out_load;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign m_hs          = m_valid_q && m_axis_tready;
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  logic [SAMP_W-1:0] samp_in;
  assign samp_in = ({2'b00, s_axis_tdata[TIME_W+SAMP_W-1:TIME_W]} > MaxBatch)
                 ? MaxBatch[SAMP_W-1:0] : s_axis_tdata[TIME_W+SAMP_W-1:TIME_W];

  // serial timestamp difference
  logic              sub_start, sub_done;
  logic [TIME_W-1:0] iv;
  assign sub_start = s_hs && !s_axis_tuser;

  sie_serial_sub u_sub (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (sub_start),
    .minuend_i    (s_axis_tdata[TIME_W-1:0]),
    .subtrahend_i (prev_q),
    .done_o       (sub_done),
    .diff_o       (iv)
  );

  // bounds
  logic          in_bounds, dflt_ok, est_ok;
  logic [CW-1:0] ivq2, est3, est1;
  assign dflt_ok = (iv[TIME_W-1:CFG_W] == '0) && (iv[CFG_W-1:0] < max_iv_q)
                && (iv[CFG_W-1:0] > min_iv_q);
  assign ivq2    = CW'(iv[EST_W-1:0]) << (FRAC_BITS + 1);
  assign est1    = CW'(be_q);
  assign est3    = est1 + (est1 << 1);
  assign est_ok  = (iv[TIME_W-1:EST_W] == '0) && (ivq2 < est3) && (ivq2 > est1);
  assign in_bounds = (be_q == '0) ? dflt_ok : est_ok;

  // accumulation
  logic [TOTAL_W:0]   tsum;
  logic [SAMPLES_W:0] ssum;
  logic [NW-1:0]      n_next;
  logic               window;
  assign tsum   = {1'b0, total_q} + (TOTAL_W+1)'(iv[EST_W-1:0]);
  assign ssum   = {1'b0, stot_q} + (SAMPLES_W+1)'(samp_q);
  assign n_next = {1'b0, tally_q} + NW'(1);
  assign window = (n_next > {1'b0, long_win_q})
               || ((be_q == '0) && (n_next > {1'b0, first_win_q}));

  // averages
  logic          div_start, div_a_done, div_b_done;
  logic [DW-1:0] div_base, div_a_q, div_b_q;
  assign div_start = (state_q == ST_DIV0);
  assign div_base  = DW'(total_q) << FRAC_BITS;

  sie_serial_div #(.DW(DW), .VW(NW)) u_div_batch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_base + DW'(n_q >> 1)),
    .divisor_i  (n_q),
    .done_o     (div_a_done),
    .quotient_o (div_a_q)
  );

  sie_serial_div #(.DW(DW), .VW(SAMPLES_W)) u_div_sample (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_base + DW'(stot_q >> 1)),
    .divisor_i  (stot_q),
    .done_o     (div_b_done),
    .quotient_o (div_b_q)
  );

  logic [MW-1:0] diff200;
  assign diff200 = (MW'(diff_q) << 7) + (MW'(diff_q) << 6) + (MW'(diff_q) << 3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iv_q    <= CFG_W'(10000);
      min_iv_q    <= CFG_W'(50);
      long_win_q  <= WIN_W'(10000);
      first_win_q <= WIN_W'(100);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_MAX_IV:    max_iv_q    <= cfg_wdata_i;
        CFG_MIN_IV:    min_iv_q    <= cfg_wdata_i;
        CFG_LONG_WIN:  long_win_q  <= cfg_wdata_i[WIN_W-1:0];
        CFG_FIRST_WIN: first_win_q <= cfg_wdata_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      prev_q    <= '0;
      total_q   <= '0;
      stot_q    <= '0;
      tally_q   <= '0;
      be_q      <= '0;
      se_q      <= '0;
      changed_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_hs) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_hs) begin
            changed_q <= 1'b0;
            if (s_axis_tuser) begin
              prev_q  <= '0;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_SUB;
            end
          end
        end
        ST_SUB: begin
          if (sub_done) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          prev_q <= now_q;
          if ((prev_q != '0) && in_bounds) begin
            total_q <= tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
            stot_q  <= ssum[SAMPLES_W] ? '1 : ssum[SAMPLES_W-1:0];
            if (window) begin
              state_q <= ST_DIV0;
            end else begin
              tally_q <= n_next[TALLY_W-1:0];
              state_q <= ST_OUT;
            end
          end else begin
            total_q <= '0;
            stot_q  <= '0;
            tally_q <= '0;
            state_q <= ST_OUT;
          end
        end
        ST_DIV0: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_a_done) begin
            state_q <= ST_DIFF;
          end
        end
        ST_DIFF: state_q <= ST_UPD;
        ST_UPD: begin
          if ((avg_q != '0) && (diff200 > MW'(be_q))) begin
            be_q      <= avg_q;
            se_q      <= savg_q;
            changed_q <= 1'b1;
          end
          total_q <= '0;
          stot_q  <= '0;
          tally_q <= '0;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      now_q  <= s_axis_tdata[TIME_W-1:0];
      samp_q <= samp_in;
    end
    if ((state_q == ST_CHECK) && window) begin
      n_q <= n_next;
    end
    if ((state_q == ST_DIV) && div_a_done) begin
      avg_q  <= (div_a_q[DW-1:EST_W] != '0) ? '1 : div_a_q[EST_W-1:0];
      savg_q <= (div_b_q[DW-1:EST_W] != '0) ? '1 : div_b_q[EST_W-1:0];
    end
    if (state_q == ST_DIFF) begin
      diff_q <= (avg_q > be_q) ? (avg_q - be_q) : (be_q - avg_q);
    end
    if (out_load) begin
      m_data_q <= {se_q, be_q};
      m_user_q <= changed_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // both dividers share a step count
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_a_done == div_b_done)
    else $error("dividers out of step");

  a_sub_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_done |-> (state_q == ST_SUB))
    else $error("subtractor finished outside of its wait state");

  a_changed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[EST_W-1:0] != '0))
    else $error("estimate reported changed to zero");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs |=> (state_q != ST_IDLE))
    else $error("beat accepted without starting work");

endmodule
